@@ design/wsd_pkg.sv @@
// ---------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the websocket client frame deframer.
// ---------------------------------------------------------------------------
package wsd_pkg;

  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 7;
  localparam int MASK_BYTES_D = 4;

  localparam logic [BYTE_W-1:0] FIN_ONLY      = 8'h80;
  localparam logic [BYTE_W-1:0] FLAG_BITS     = 8'hf0;
  localparam logic [BYTE_W-1:0] MASK_FLAG     = 8'h80;
  localparam logic [3:0]        OPCODE_BINARY = 4'h2;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT  = 7'd125;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_EMPTY      = 2'd1,
    KIND_BAD_HEADER = 2'd2,
    KIND_BAD_OPCODE = 2'd3
  } kind_t;

  // one result item plus its valid flag
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
    kind_t             kind;
  } result_t;

endpackage

@@ design/wsd_parser.sv @@
// ---------------------------------------------------------------------------
// wsd_parser
// Frame state machine: collects the header and mask key, checks the header
// and unmasks payload bytes. The result is combinational from the current
// state and the byte; state advances on step.
// ---------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int MASK_BYTES = MASK_BYTES_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [LEN_W-1:0]  max_len,
  output result_t           res
);

  localparam int MIDX_W = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
  localparam logic [MIDX_W-1:0] MIDX_LAST = MIDX_W'(MASK_BYTES - 1);

  typedef enum logic [4:0] {
    ST_FLAGS   = 5'b00001,
    ST_LENGTH  = 5'b00010,
    ST_MASK    = 5'b00100,
    ST_PAYLOAD = 5'b01000,
    ST_HALT    = 5'b10000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   first_r, first_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                mbit_r, mbit_nxt;
  logic [LEN_W-1:0]    count_r, count_nxt;
  logic [MIDX_W-1:0]   midx_r, midx_nxt;
  logic [BYTE_W-1:0]   key_r [MASK_BYTES];
  logic                key_we;
  logic [LEN_W-1:0]    count_inc;
  logic                hdr_bad;

  assign count_inc = count_r + LEN_W'(1);
  assign hdr_bad   = ((first_r & FLAG_BITS) != FIN_ONLY) || (len_r > max_len) || !mbit_r;

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    mbit_nxt  = mbit_r;
    count_nxt = count_r;
    midx_nxt  = midx_r;
    key_we    = 1'b0;
    res       = '{valid: 1'b0, data: '0, last: 1'b0, kind: KIND_DATA};
    case (phase_r)
      ST_FLAGS: begin
        first_nxt = byte_in;
        phase_nxt = ST_LENGTH;
      end
      ST_LENGTH: begin
        len_nxt   = byte_in[LEN_W-1:0];
        mbit_nxt  = |(byte_in & MASK_FLAG);
        midx_nxt  = '0;
        phase_nxt = ST_MASK;
      end
      ST_MASK: begin
        key_we   = 1'b1;
        midx_nxt = midx_r + MIDX_W'(1);
        if (midx_r == MIDX_LAST) begin
          midx_nxt  = '0;
          count_nxt = '0;
          res.valid = 1'b1;
          res.last  = 1'b1;
          if (hdr_bad) begin
            res.kind  = KIND_BAD_HEADER;
            phase_nxt = ST_HALT;
          end else if (first_r[3:0] != OPCODE_BINARY) begin
            res.kind  = KIND_BAD_OPCODE;
            phase_nxt = ST_HALT;
          end else if (len_r == '0) begin
            res.kind  = KIND_EMPTY;
            phase_nxt = ST_FLAGS;
          end else begin
            res.valid = 1'b0;
            res.last  = 1'b0;
            phase_nxt = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        count_nxt = count_inc;
        midx_nxt  = (midx_r == MIDX_LAST) ? '0 : midx_r + MIDX_W'(1);
        res.valid = 1'b1;
        res.data  = byte_in ^ key_r[midx_r];
        res.kind  = KIND_DATA;
        if (count_inc >= len_r) begin
          res.last  = 1'b1;
          phase_nxt = ST_FLAGS;
        end
      end
      ST_HALT: begin
        phase_nxt = ST_HALT;
      end
      default: begin
        phase_nxt = ST_HALT;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_FLAGS;
      first_r <= '0;
      len_r   <= '0;
      mbit_r  <= 1'b0;
      count_r <= '0;
      midx_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      mbit_r  <= mbit_nxt;
      count_r <= count_nxt;
      midx_r  <= midx_nxt;
    end
  end

  // mask key bytes
  always_ff @(posedge clk) begin
    if (step && key_we) begin
      key_r[midx_r] <= byte_in;
    end
  end

endmodule

@@ design/wsd_out_reg.sv @@
// ---------------------------------------------------------------------------
// wsd_out_reg
// Result register of the deframer; holds one item while the sink stalls.
// ---------------------------------------------------------------------------
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  result_t           res,
  input  logic              out_stall,
  output logic              slot_free,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_frame,
  output logic [1:0]        out_result_kind
);

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] data_r;
  logic              last_r;
  kind_t             kind_r;

  assign slot_free = !valid_r || !out_stall;

  // valid tracking
  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (slot_free && load && res.valid) begin
      data_r <= res.data;
      last_r <= res.last;
      kind_r <= res.kind;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = data_r;
  assign out_last_of_frame = last_r;
  assign out_result_kind   = kind_r;

endmodule

@@ design/websocket_client_frame_deframer_top.sv @@
// ---------------------------------------------------------------------------
// websocket_client_frame_deframer_top
// Receives client-to-server websocket frames and gives unmasked payload bytes.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low and gives at most one result
// item per byte: a byte goes into the input register, the frame state
// machine handles it combinationally and the result register
// presents it. Frames have a six-byte header (flags/opcode, mask bit and
// 7-bit length, four mask bytes). A header that is not FIN-only binary,
// masked and within cfg_max_payload_length gives one error item and the
// block ignores all further bytes until reset. A zero-length frame gives one
// empty-frame item. Configuration writes saturate at 125 and are always ready.
module websocket_client_frame_deframer_top
  import wsd_pkg::*;
#(
  parameter int MASK_BYTES = MASK_BYTES_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_frame,
  output logic [1:0]        out_result_kind,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_max_payload_length
);

  logic              in_v_r, in_v_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic [LEN_W-1:0]  max_len_r, max_len_nxt;
  logic              slot_free;
  logic              adv;
  result_t           res;

  assign adv       = in_v_r && slot_free;
  assign in_stall  = in_v_r && !slot_free;
  assign cfg_ready = 1'b1;

  // configuration register with saturation
  assign max_len_nxt = (cfg_max_payload_length > LENGTH_LIMIT) ? LENGTH_LIMIT
                                                               : cfg_max_payload_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LENGTH_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= max_len_nxt;
    end
  end

  // input register
  always_comb begin
    in_v_nxt = in_v_r;
    if (!in_stall) begin
      in_v_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  wsd_parser #(
    .MASK_BYTES(MASK_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .byte_in (in_byte_r),
    .max_len (max_len_r),
    .res     (res)
  );

  wsd_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (adv),
    .res               (res),
    .out_stall         (out_stall),
    .slot_free         (slot_free),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_result_kind   (out_result_kind)
  );

  // non-data items carry a zero byte
  a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != KIND_DATA) |-> out_byte == '0)
    else $error("non-data item with nonzero byte");

  // error items always end the frame
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_BAD_HEADER || out_result_kind == KIND_BAD_OPCODE)
    |-> out_last_of_frame)
    else $error("error item without last flag");

  // length limit stays within the supported range
  a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
    max_len_r <= LENGTH_LIMIT)
    else $error("length limit above supported range");

  // input stalls only while an item is held and the result slot is busy
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r && out_valid && out_stall)
    else $error("input stalled without a busy result slot");

endmodule

@@ test/ws_frame_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ws_frame_checker
// Watches the byte, result and configuration channels of the deframer, works
// out the expected result items from every accepted byte and compares them
// in order with the accepted result items.
// ---------------------------------------------------------------------------
module ws_frame_checker
  import wsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_last_of_frame,
  input  logic [1:0]        out_result_kind,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_max_payload_length,
  output int                mismatch_count,
  output int                results_waiting
);

  typedef enum logic [2:0] {
    PH_FLAGS,
    PH_LENGTH,
    PH_KEY0,
    PH_KEY1,
    PH_KEY2,
    PH_KEY3,
    PH_PAYLOAD,
    PH_HALTED
  } rx_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    kind_t             kind;
  } frame_result_t;

  frame_result_t     frame_results_q[$];
  rx_phase_t         rx_phase;
  logic [BYTE_W-1:0] hdr_flags;
  logic [LEN_W-1:0]  rx_len;
  logic [LEN_W-1:0]  rx_count;
  logic [LEN_W-1:0]  max_len;
  logic              masked;
  logic [BYTE_W-1:0] key [MASK_BYTES_D];
  int                errs;

  initial begin
    mismatch_count  = 0;
    results_waiting = 0;
    errs            = 0;
  end

  function automatic frame_result_t make_result(logic [BYTE_W-1:0] data, logic last,
                                                kind_t kind);
    frame_result_t r;
    r.data = data;
    r.last = last;
    r.kind = kind;
    return r;
  endfunction

  // header check on the last mask byte
  task automatic check_header();
    if ((hdr_flags & FLAG_BITS) != FIN_ONLY || rx_len > max_len || !masked) begin
      frame_results_q.push_back(make_result('0, 1'b1, KIND_BAD_HEADER));
      rx_phase = PH_HALTED;
    end else if (hdr_flags[3:0] != OPCODE_BINARY) begin
      frame_results_q.push_back(make_result('0, 1'b1, KIND_BAD_OPCODE));
      rx_phase = PH_HALTED;
    end else begin
      rx_count = '0;
      if (rx_len == 0) begin
        frame_results_q.push_back(make_result('0, 1'b1, KIND_EMPTY));
        rx_phase = PH_FLAGS;
      end else begin
        rx_phase = PH_PAYLOAD;
      end
    end
  endtask

  // next state and result for one received byte
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] plain;
    logic              last;
    case (rx_phase)
      PH_FLAGS: begin
        hdr_flags = b;
        rx_phase  = PH_LENGTH;
      end
      PH_LENGTH: begin
        rx_len   = b[LEN_W-1:0];
        masked   = (b & MASK_FLAG) != 0;
        rx_phase = PH_KEY0;
      end
      PH_KEY0: begin
        key[0]   = b;
        rx_phase = PH_KEY1;
      end
      PH_KEY1: begin
        key[1]   = b;
        rx_phase = PH_KEY2;
      end
      PH_KEY2: begin
        key[2]   = b;
        rx_phase = PH_KEY3;
      end
      PH_KEY3: begin
        key[3] = b;
        check_header();
      end
      PH_PAYLOAD: begin
        plain    = b ^ key[rx_count[1:0]];
        rx_count = rx_count + 1'b1;
        last     = rx_count >= rx_len;
        if (last) rx_phase = PH_FLAGS;
        frame_results_q.push_back(make_result(plain, last, KIND_DATA));
      end
      default: ;  // halted: byte ignored
    endcase
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      frame_results_q.delete();
      rx_phase  = PH_FLAGS;
      hdr_flags = '0;
      rx_len    = '0;
      rx_count  = '0;
      masked    = 1'b0;
      max_len   = LENGTH_LIMIT;
    end else begin
      // compare an accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result item: byte %02h last %0b kind %0d",
                     $realtime, out_byte, out_last_of_frame, out_result_kind);
        end else begin
          want = frame_results_q.pop_front();
          if (out_byte !== want.data || out_last_of_frame !== want.last ||
              out_result_kind !== want.kind) begin
            errs++;
            if (errs <= 10) begin
              $write("%0t: result mismatch: expected byte %02h last %0b kind %s,",
                     $realtime, want.data, want.last, want.kind.name());
              $display(" got byte %02h last %0b kind %0d", out_byte, out_last_of_frame,
                       out_result_kind);
            end
          end
        end
      end
      // register write, saturating at the largest plain length
      if (cfg_valid && cfg_ready)
        max_len = (cfg_max_payload_length > LENGTH_LIMIT) ? LENGTH_LIMIT
                                                         : cfg_max_payload_length;
      // accepted byte
      if (in_valid && !in_stall) deframe_byte(in_byte);
    end
    mismatch_count  <= errs;
    results_waiting <= frame_results_q.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench of the websocket client frame deframer.
// Sends directed frames, then phases of random well-formed masked frames
// under several length limits with random gaps and stalls, and ends with one
// broken header that halts the block. A checker compares every result item.
// ---------------------------------------------------------------------------
module tb;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT      = 800_000;
  localparam int BYTES_PER_PHASE  = 330;
  localparam int N_PHASES         = 6;
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef enum int {
    BREAK_FLAGS,
    BREAK_LENGTH,
    BREAK_MASK,
    BREAK_OPCODE
  } header_break_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_of_frame;
  logic [1:0]        out_result_kind;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_max_payload_length;

  int   mismatch_count;
  int   results_waiting;
  int   cycle_count;
  int   bytes_sent;
  int   calm_left;
  logic long_hold_req;

  websocket_client_frame_deframer_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_byte                (in_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_byte               (out_byte),
    .out_last_of_frame      (out_last_of_frame),
    .out_result_kind        (out_result_kind),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_max_payload_length (cfg_max_payload_length)
  );

  ws_frame_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_byte                (in_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_byte               (out_byte),
    .out_last_of_frame      (out_last_of_frame),
    .out_result_kind        (out_result_kind),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_max_payload_length (cfg_max_payload_length),
    .mismatch_count         (mismatch_count),
    .results_waiting        (results_waiting)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle counter and timeout
  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // sender gap: mostly none or short, a few long, with calm stretches
  function automatic int next_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(10, 40);
    calm_left = $urandom_range(100, 300);
    return 0;
  endfunction

  function automatic logic [LEN_W-1:0] saturate_len(logic [LEN_W-1:0] v);
    return (v > LENGTH_LIMIT) ? LENGTH_LIMIT : v;
  endfunction

  // mostly short frames, sometimes anything up to the limit
  function automatic int pick_len(int limit);
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, (limit < 12) ? limit : 12);
    return $urandom_range(0, limit);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // header of a masked binary frame, then the payload; fill < 0 means random bytes
  task automatic send_frame(input int len, input logic [31:0] key, input int fill);
    send_byte(FIN_ONLY | {4'h0, OPCODE_BINARY});
    send_byte(MASK_FLAG | 8'(len));
    for (int i = 0; i < MASK_BYTES_D; i++) send_byte(key[8*i +: 8]);
    for (int i = 0; i < len; i++) send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  // let every expected item come out before touching the register
  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the count catch up with the last accepted byte
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    cfg_valid              <= 1'b1;
    cfg_max_payload_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int stall_left;
    int free_left;
    int roll;
    logic hold_served;
    stall_left  = 0;
    free_left   = 0;
    hold_served = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        roll = $urandom_range(0, 99);
        if (free_left > 0) free_left--;
        else if (roll < 20) stall_left = $urandom_range(1, 3);
        else if (roll < 22) stall_left = $urandom_range(10, 40);
        else if (roll < 24) free_left = $urandom_range(50, 200);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [LEN_W-1:0]  cfg_plan [N_PHASES];
    logic [LEN_W-1:0]  limit;
    logic [BYTE_W-1:0] flags;
    logic [BYTE_W-1:0] len_byte;
    header_break_t     how;
    int                phase_start;

    rst_n                  <= 1'b0;
    in_valid               <= 1'b0;
    in_byte                <= '0;
    cfg_valid              <= 1'b0;
    cfg_max_payload_length <= '0;
    long_hold_req          <= 1'b0;
    bytes_sent             = 0;
    calm_left              = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, all-ones byte against all-ones key, mask rotation
    send_frame(0, $urandom, -1);
    send_frame(1, 32'hffff_ffff, 8'hff);
    send_frame(5, 32'h5aa5_ff00, -1);

    // random frames under several limits, extremes among them
    cfg_plan = '{LENGTH_LIMIT, 7'd0, 7'd127, 7'd1, 7'd126, 7'($urandom_range(2, 124))};
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_max_len(cfg_plan[p]);
      end
      limit = saturate_len(cfg_plan[p]);
      if (p == 2) long_hold_req <= 1'b1;
      phase_start = bytes_sent;
      send_frame(limit, $urandom, -1);
      while (bytes_sent - phase_start < BYTES_PER_PHASE)
        send_frame(pick_len(limit), $urandom, -1);
    end

    // one broken header to end the stream; the block halts for good
    wait_drained();
    write_max_len(7'($urandom));
    limit    = saturate_len(cfg_max_payload_length);
    flags    = FIN_ONLY | {4'h0, OPCODE_BINARY};
    len_byte = MASK_FLAG | 8'(pick_len(limit));
    how      = header_break_t'($urandom_range(0, 3));
    case (how)
      BREAK_FLAGS: begin
        do flags[7:4] = 4'($urandom); while (flags[7:4] == FIN_ONLY[7:4]);
      end
      BREAK_LENGTH: len_byte = MASK_FLAG | 8'($urandom_range(int'(limit) + 1, 127));
      BREAK_MASK:   len_byte = len_byte & ~MASK_FLAG;
      default: begin
        do flags[3:0] = 4'($urandom); while (flags[3:0] == OPCODE_BINARY);
      end
    endcase
    send_byte(flags);
    send_byte(len_byte);
    for (int i = 0; i < MASK_BYTES_D; i++) send_byte(8'($urandom));
    // bytes after the error are ignored
    for (int i = 0; i < 20; i++) send_byte(8'($urandom));

    wait_drained();
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
